// ----- rtl/mcr_pkg.sv -----
// Shared types and constants for the midpoint circle rasterizer.
package mcr_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic
    {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } req_type_t;

    typedef struct packed
    {
        logic       req_type;
        logic [7:0] center_x;
        logic [7:0] center_y;
        logic [7:0] radius;
        logic [7:0] pixel_value;
        logic       fill_mode;
    } req_t;

    typedef struct packed
    {
        logic [7:0] point_x;
        logic [7:0] point_y;
        logic [7:0] point_value;
        logic       octet_last;
        logic       circle_done;
    } point_t;

    // One octet of work: center, the (a, b) pair, the pixel value and the end-of-circle mark.
    typedef struct packed
    {
        logic [7:0] cx;
        logic [7:0] cy;
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] value;
        logic       done;
    } job_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- rtl/mcr_front.sv -----
// Front end: takes transactions, keeps the midpoint stepping state, queues octet jobs.
module mcr_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  mcr_pkg::req_t req,
    output logic          push,
    output mcr_pkg::job_t job
);
    import mcr_pkg::*;

    logic [7:0]        cx_reg, cx_next;
    logic [7:0]        cy_reg, cy_next;
    logic [7:0]        value_reg, value_next;
    logic              fill_reg, fill_next;
    logic [7:0]        x_reg, x_next;
    logic signed [8:0] y_reg, y_next;
    logic [7:0]        inner_reg, inner_next;
    logic signed [12:0] d_reg, d_next;
    logic              active_reg, active_next;

    logic signed [8:0]  diff;
    logic signed [12:0] diff_ext;
    logic signed [12:0] inc_neg;
    logic signed [12:0] inc_pos;
    logic [7:0]         b_sel;
    logic               finished;

    always_comb
    begin
        diff     = $signed({1'b0, x_reg}) - y_reg;
        diff_ext = {{4{diff[8]}}, diff};
        inc_neg  = $signed({3'b000, x_reg, 2'b00}) + 13'sd6;
        inc_pos  = $signed({diff_ext[10:0], 2'b00}) + 13'sd10;
        b_sel    = fill_reg ? inner_reg : y_reg[7:0];

        cx_next     = cx_reg;
        cy_next     = cy_reg;
        value_next  = value_reg;
        fill_next   = fill_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        inner_next  = inner_reg;
        d_next      = d_reg;
        active_next = active_reg;
        finished    = 1'b0;
        push        = 1'b0;

        if (accept)
        begin
            if (req.req_type == REQ_START)
            begin
                cx_next     = req.center_x;
                cy_next     = req.center_y;
                value_next  = req.pixel_value;
                fill_next   = req.fill_mode;
                x_next      = '0;
                y_next      = $signed({1'b0, req.radius});
                inner_next  = '0;
                d_next      = 13'sd3 - $signed({4'b0000, req.radius, 1'b0});
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                push = 1'b1;
                if (fill_reg && (inner_reg < y_reg[7:0]))
                begin
                    inner_next = inner_reg + 8'd1;
                end
                else
                begin
                    if (d_reg < 0)
                    begin
                        d_next = d_reg + inc_neg;
                    end
                    else
                    begin
                        d_next = d_reg + inc_pos;
                        y_next = y_reg - 9'sd1;
                    end
                    x_next     = x_reg + 8'd1;
                    inner_next = x_next;
                    // y may reach -1 for radius zero, so compare signed
                    finished   = $signed({1'b0, x_next}) > y_next;
                    if (finished)
                    begin
                        active_next = 1'b0;
                    end
                end
            end
        end

        job.cx    = cx_reg;
        job.cy    = cy_reg;
        job.a     = x_reg;
        job.b     = b_sel;
        job.value = value_reg;
        job.done  = finished;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            value_reg  <= '0;
            fill_reg   <= 1'b0;
            x_reg      <= '0;
            y_reg      <= '0;
            inner_reg  <= '0;
            d_reg      <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            value_reg  <= value_next;
            fill_reg   <= fill_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            inner_reg  <= inner_next;
            d_reg      <= d_next;
            active_reg <= active_next;
        end
    end

endmodule

// ----- rtl/mcr_queue.sv -----
// Short job queue between the front end and the point emitter.
module mcr_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  mcr_pkg::job_t          push_job,
    input  logic                   pop,
    output mcr_pkg::job_t          head,
    output mcr_pkg::queue_status_t status
);
    import mcr_pkg::*;

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    job_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    always_comb
    begin
        status.full  = (count_reg == CW'(QUEUE_DEPTH));
        status.empty = (count_reg == '0);
        do_push      = push && !status.full;
        do_pop       = pop && !status.empty;
        head         = entry_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/mcr_back.sv -----
// Back end: expands each queued job into its eight symmetric points, one per cycle.
module mcr_back
#(
    parameter int unsigned COORD_BITS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mcr_pkg::job_t          head,
    input  mcr_pkg::queue_status_t status,
    output logic                   pop,
    output logic                   result_strobe,
    output mcr_pkg::point_t        result
);
    import mcr_pkg::*;

    localparam int unsigned OW = (COORD_BITS < 8) ? COORD_BITS : 8;

    typedef enum logic [1:0]
    {
        BK_IDLE = 2'b01,
        BK_EMIT = 2'b10
    } back_state_t;

    back_state_t state_reg, state_next;
    job_t        cur_reg, cur_next;
    logic [2:0]  idx_reg, idx_next;
    point_t      result_reg, result_next;
    logic        strobe_reg, strobe_next;

    logic [COORD_BITS-1:0] cx_w;
    logic [COORD_BITS-1:0] cy_w;
    logic [COORD_BITS-1:0] u_w;
    logic [COORD_BITS-1:0] v_w;
    logic [COORD_BITS-1:0] px_w;
    logic [COORD_BITS-1:0] py_w;

    always_comb
    begin
        // idx[2] swaps the pair, idx[0] negates the column term, idx[1] the row term
        cx_w = COORD_BITS'(cur_reg.cx);
        cy_w = COORD_BITS'(cur_reg.cy);
        u_w  = idx_reg[2] ? COORD_BITS'(cur_reg.b) : COORD_BITS'(cur_reg.a);
        v_w  = idx_reg[2] ? COORD_BITS'(cur_reg.a) : COORD_BITS'(cur_reg.b);
        px_w = idx_reg[0] ? (cx_w - u_w) : (cx_w + u_w);
        py_w = idx_reg[1] ? (cy_w - v_w) : (cy_w + v_w);

        state_next  = state_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        pop         = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!status.empty)
                begin
                    pop        = 1'b1;
                    cur_next   = head;
                    idx_next   = '0;
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                strobe_next             = 1'b1;
                result_next.point_x     = 8'(px_w[OW-1:0]);
                result_next.point_y     = 8'(py_w[OW-1:0]);
                result_next.point_value = cur_reg.value;
                result_next.octet_last  = (idx_reg == 3'd7);
                result_next.circle_done = (idx_reg == 3'd7) && cur_reg.done;
                idx_next                = idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    if (!status.empty)
                    begin
                        pop      = 1'b1;
                        cur_next = head;
                    end
                    else
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            idx_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            strobe_reg <= strobe_next;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

// ----- rtl/midpoint_circle_rasterizer_top.sv -----
// Top level of the midpoint circle rasterizer: front end, job queue, point emitter.
//
// Input channel: a transaction is taken at a rising edge with start high and busy low.
// A start transaction (req_type = 0) loads center, radius, value and fill flag and
// gives no points. A step transaction (req_type = 1) gives eight points of the
// current octet, or nothing once the circle is finished or none was started.
// Output channel: each point is on result for exactly one cycle with result_strobe
// high; the receiver must take it then, there is no backpressure.
// A step's job passes the queue entry, the emitter's job register and the result
// register. Throughput: the emitter sends one point a cycle, eight points per step;
// queued steps follow each other with no gap. The front end updates the stepping
// state in the cycle it takes a step and parks the job in a two-entry queue; busy
// is high while that queue is full. Start transactions are taken whenever busy is
// low and do not disturb octets already queued.
// Reset clears all control state: no circle active, queue empty, no strobe.
module midpoint_circle_rasterizer_top
#(
    parameter int unsigned COORD_BITS = 8
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  mcr_pkg::req_t   req,
    output logic            result_strobe,
    output mcr_pkg::point_t result
);
    import mcr_pkg::*;

    logic          accept;
    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          head;
    queue_status_t status;

    assign busy   = status.full;
    assign accept = start && !status.full;

    mcr_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req),
        .push   (push),
        .job    (push_job)
    );

    mcr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (status)
    );

    mcr_back
    #(
        .COORD_BITS (COORD_BITS)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .status        (status),
        .pop           (pop),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

// ----- sim/circle_point_checker.sv -----
// Checker for the circle rasterizer: predicts each octet of points and compares the point stream.
module circle_point_checker
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  mcr_pkg::req_t   req,
    input  logic            result_strobe,
    input  mcr_pkg::point_t result,
    output int              fail_count,
    output int              pending
);
    import mcr_pkg::*;

    // Predicted circle state
    logic [7:0]         cx_q;
    logic [7:0]         cy_q;
    logic [7:0]         value_q;
    logic               fill_q;
    logic signed [9:0]  cur_x;
    logic signed [9:0]  cur_y;
    logic signed [9:0]  cur_inner;
    logic signed [12:0] decision_q;
    logic               drawing;

    point_t expected_points[$];
    int     errors;
    int     reported;

    task automatic predict_octet(input req_t rq);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] off_x[8];
        logic [7:0] off_y[8];
        logic       finished;
        point_t     pt;
        if (req_type_t'(rq.req_type) == REQ_START)
        begin
            cx_q       = rq.center_x;
            cy_q       = rq.center_y;
            value_q    = rq.pixel_value;
            fill_q     = rq.fill_mode;
            cur_x      = '0;
            cur_y      = signed'({2'b00, rq.radius});
            cur_inner  = '0;
            decision_q = 13'(3 - 2 * cur_y);
            drawing    = 1'b1;
        end
        else if (drawing)
        begin
            a = cur_x[7:0];
            b = fill_q ? cur_inner[7:0] : cur_y[7:0];
            off_x = '{a, -a, a, -a, b, -b, b, -b};
            off_y = '{b, b, -b, -b, a, a, -a, -a};

            // advance before emitting so the done flag is known for the eighth point
            finished = 1'b0;
            if (fill_q && cur_inner < cur_y)
            begin
                cur_inner = 10'(cur_inner + 1);
            end
            else
            begin
                if (decision_q < 0)
                begin
                    decision_q = 13'(decision_q + 4 * cur_x + 6);
                end
                else
                begin
                    decision_q = 13'(decision_q + 4 * (cur_x - cur_y) + 10);
                    cur_y = 10'(cur_y - 1);
                end
                cur_x = 10'(cur_x + 1);
                cur_inner = cur_x;
                if (cur_x > cur_y)
                    finished = 1'b1;
            end

            for (int k = 0; k < 8; k++)
            begin
                pt.point_x     = cx_q + off_x[k];
                pt.point_y     = cy_q + off_y[k];
                pt.point_value = value_q;
                pt.octet_last  = (k == 7);
                pt.circle_done = finished && (k == 7);
                expected_points.push_back(pt);
            end
            if (finished)
                drawing = 1'b0;
        end
    endtask

    task automatic check_point(input point_t got);
        point_t want;
        if (expected_points.size() == 0)
        begin
            errors++;
            if (reported < 10)
            begin
                reported++;
                $display("ERROR: unexpected point x=%0d y=%0d v=%0d last=%0b done=%0b",
                         got.point_x, got.point_y, got.point_value,
                         got.octet_last, got.circle_done);
            end
        end
        else
        begin
            want = expected_points.pop_front();
            if (got.point_x !== want.point_x || got.point_y !== want.point_y ||
                got.point_value !== want.point_value ||
                got.octet_last !== want.octet_last ||
                got.circle_done !== want.circle_done)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("ERROR: point mismatch exp x=%0d y=%0d v=%0d last=%0b done=%0b",
                             want.point_x, want.point_y, want.point_value,
                             want.octet_last, want.circle_done);
                    $display("                      got x=%0d y=%0d v=%0d last=%0b done=%0b",
                             got.point_x, got.point_y, got.point_value,
                             got.octet_last, got.circle_done);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_q       = '0;
            cy_q       = '0;
            value_q    = '0;
            fill_q     = 1'b0;
            cur_x      = '0;
            cur_y      = '0;
            cur_inner  = '0;
            decision_q = '0;
            drawing    = 1'b0;
            expected_points.delete();
            errors     = 0;
            reported   = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (start && !busy)
                predict_octet(req);
            if (result_strobe)
                check_point(result);
            fail_count <= errors;
            pending    <= expected_points.size();
        end
    end

endmodule

// ----- sim/testbench.sv -----
// Top of the circle rasterizer testbench: clock, reset, request stimulus, watchdog and verdict.
module testbench;
    import mcr_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    req_t   req;
    logic   result_strobe;
    point_t result;
    int     fail_count;
    int     pending;
    int     sent;
    int     stall_cycles;

    midpoint_circle_rasterizer_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .result_strobe (result_strobe),
        .result        (result)
    );

    circle_point_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req           (req),
        .result_strobe (result_strobe),
        .result        (result),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Watchdog: cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((start && !busy) || result_strobe || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic req_t random_fields(input req_type_t kind);
        req_t rq;
        rq.req_type    = kind;
        rq.center_x    = 8'($urandom_range(255));
        rq.center_y    = 8'($urandom_range(255));
        rq.radius      = 8'($urandom_range(255));
        rq.pixel_value = 8'($urandom_range(255));
        rq.fill_mode   = 1'($urandom_range(1));
        return rq;
    endfunction

    function automatic req_t circle_req(input logic [7:0] x, input logic [7:0] y,
                                        input logic [7:0] r, input logic [7:0] v,
                                        input logic fill);
        req_t rq;
        rq.req_type    = REQ_START;
        rq.center_x    = x;
        rq.center_y    = y;
        rq.radius      = r;
        rq.pixel_value = v;
        rq.fill_mode   = fill;
        return rq;
    endfunction

    // Drive one transaction; returns at the edge where it was taken.
    task automatic send(input req_t rq, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            req   <= random_fields(req_type_t'($urandom_range(1)));
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= rq;
        do
            @(posedge clk);
        while (busy);
        sent++;
    endtask

    task automatic send_steps(input int count, input int idle_pct);
        for (int i = 0; i < count; i++)
            send(random_fields(REQ_STEP), idle_pct);
    endtask

    task automatic drain;
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic random_phase(input int idle_pct, input int quota);
        int   limit;
        int   steps;
        req_t rq;
        while (sent < quota)
        begin
            if ($urandom_range(9) == 0)
            begin
                // noise: bare steps, possibly into an idle rasterizer
                send_steps($urandom_range(1, 3), idle_pct);
            end
            else
            begin
                rq = random_fields(REQ_START);
                if ($urandom_range(9) == 0)
                    rq.radius = 8'($urandom_range(128, 255));
                else
                    rq.radius = 8'($urandom_range(rq.fill_mode ? 6 : 14));
                if (rq.radius > 14)
                    limit = 6;
                else if (rq.fill_mode)
                    limit = rq.radius * rq.radius / 2 + rq.radius + 4;
                else
                    limit = rq.radius + 3;
                steps = $urandom_range(1, limit);
                send(rq, idle_pct);
                send_steps(steps, idle_pct);
            end
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        req          = '0;
        sent         = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step with no circle active
        send_steps(1, 0);
        // zero radius, outline, corner center, then a step after the circle ended
        send(circle_req(8'd0, 8'd0, 8'd0, 8'd255, 1'b0), 0);
        send_steps(2, 0);
        // zero radius in fill mode at the far corner
        send(circle_req(8'd255, 8'd255, 8'd0, 8'd0, 1'b1), 0);
        send_steps(1, 0);
        // largest radius, wrapping coordinates
        send(circle_req(8'd255, 8'd0, 8'd255, 8'd170, 1'b0), 0);
        send_steps(3, 0);
        send(circle_req(8'd0, 8'd255, 8'd255, 8'd15, 1'b1), 0);
        send_steps(2, 0);
        // new circle dropped in while one is running; runs to the end plus one idle step
        send(circle_req(8'd128, 8'd128, 8'd3, 8'd85, 1'b0), 0);
        send_steps(4, 0);
        drain();

        random_phase(35, sent + 70);
        drain();
        random_phase(50, sent + 70);
        drain();
        random_phase(0, sent + 70);

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/mcr_pkg.sv
rtl/mcr_front.sv
rtl/mcr_queue.sv
rtl/mcr_back.sv
rtl/midpoint_circle_rasterizer_top.sv
sim/circle_point_checker.sv
sim/testbench.sv
